// ===== hw/rtl/brl_pkg.sv =====
// shared constants, codes and width helpers for the line rasterizer
package brl_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd3;

    // queue entry: minor, major, y0, x0, y_dir, x_dir, swapped, cmd (highest first)
    function automatic int entry_w(input int cb);
        return 4 * cb + 6;
    endfunction

    function automatic int in_data_w(input int cb);
        return ((4 * cb + 7) / 8) * 8;
    endfunction

    function automatic int out_data_w(input int cb);
        return ((2 * cb + 7) / 8) * 8;
    endfunction

endpackage

// ===== hw/rtl/brl_front.sv =====
// front end: classifies requests and works out spans, step signs and major axis
module brl_front
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                               i_cmd,
    input  logic [COORD_BITS-1:0]              i_x_start,
    input  logic [COORD_BITS-1:0]              i_y_start,
    input  logic [COORD_BITS-1:0]              i_x_end,
    input  logic [COORD_BITS-1:0]              i_y_end,
    output logic [entry_w(COORD_BITS)-1:0]     o_entry
);

    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [1:0]            x_dir;
    logic [1:0]            y_dir;
    logic                  swapped;

    always_comb begin
        span_x = (i_x_start >= i_x_end) ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        span_y = (i_y_start >= i_y_end) ? (i_y_start - i_y_end) : (i_y_end - i_y_start);

        if (i_x_end > i_x_start) begin
            x_dir = DIR_POS;
        end else if (i_x_end < i_x_start) begin
            x_dir = DIR_NEG;
        end else begin
            x_dir = DIR_NONE;
        end

        if (i_y_end > i_y_start) begin
            y_dir = DIR_POS;
        end else if (i_y_end < i_y_start) begin
            y_dir = DIR_NEG;
        end else begin
            y_dir = DIR_NONE;
        end

        // ties keep x as the major axis
        swapped = (span_y > span_x);
        major   = swapped ? span_y : span_x;
        minor   = swapped ? span_x : span_y;
    end

    assign o_entry = {minor, major, i_y_start, i_x_start, y_dir, x_dir, swapped, i_cmd};

endmodule

// ===== hw/rtl/brl_queue.sv =====
// short request queue between the front end and the pixel walker
module brl_queue
    import brl_pkg::*;
#(
    parameter int WIDTH = entry_w(COORD_BITS_DEF),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/brl_walker.sv =====
// back end: loads lines, walks the error term and holds the pixel output register
module brl_walker
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [entry_w(COORD_BITS)-1:0] i_q_entry,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic                           o_last
);

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 2;
    localparam int WW = CB + 3;

    logic          e_cmd;
    logic          e_swapped;
    logic [1:0]    e_x_dir;
    logic [1:0]    e_y_dir;
    logic [CB-1:0] e_x0;
    logic [CB-1:0] e_y0;
    logic [CB-1:0] e_major;
    logic [CB-1:0] e_minor;

    logic [CB-1:0] r_cur_x;
    logic [CB-1:0] r_cur_y;
    logic [EW-1:0] r_err;
    logic [CB-1:0] r_major;
    logic [CB-1:0] r_minor;
    logic [CB:0]   r_left;
    logic [1:0]    r_x_dir;
    logic [1:0]    r_y_dir;
    logic          r_swapped;
    logic          r_active;
    logic          r_out_valid;
    logic [CB-1:0] r_out_x;
    logic [CB-1:0] r_out_y;
    logic          r_out_last;

    logic          out_free;
    logic          load;
    logic          emit;
    logic          err_neg;
    logic          minor_move;
    logic [WW-1:0] err_wide;
    logic [WW-1:0] n_err_wide;
    logic [WW-1:0] init_wide;
    logic [CB-1:0] n_x;
    logic [CB-1:0] n_y;
    logic          is_last;

    function automatic logic [CB-1:0] move(input logic [CB-1:0] c, input logic [1:0] d);
        logic [CB-1:0] r;
        unique case (d)
            DIR_POS: r = c + CB'(1);
            DIR_NEG: r = c - CB'(1);
            default: r = c;
        endcase
        return r;
    endfunction

    assign {e_minor, e_major, e_y0, e_x0, e_y_dir, e_x_dir, e_swapped, e_cmd} = i_q_entry;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_q_pop  = i_q_valid && ((e_cmd == CMD_START) || !r_active || out_free);
    assign load     = o_q_pop && (e_cmd == CMD_START);
    assign emit     = o_q_pop && (e_cmd == CMD_STEP) && r_active;
    assign is_last  = (r_left == (CB + 1)'(1));

    always_comb begin
        err_neg    = r_err[EW-1];
        minor_move = !err_neg;
        err_wide   = {r_err[EW-1], r_err};
        n_err_wide = err_wide + {2'b00, r_minor, 1'b0}
                     - (err_neg ? '0 : {2'b00, r_major, 1'b0});
        init_wide  = {2'b00, e_minor, 1'b0} - {3'b000, e_major};
        if (r_swapped) begin
            n_y = move(r_cur_y, r_y_dir);
            n_x = minor_move ? move(r_cur_x, r_x_dir) : r_cur_x;
        end else begin
            n_x = move(r_cur_x, r_x_dir);
            n_y = minor_move ? move(r_cur_y, r_y_dir) : r_cur_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (emit && is_last) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur_x   <= e_x0;
            r_cur_y   <= e_y0;
            r_err     <= init_wide[EW-1:0];
            r_major   <= e_major;
            r_minor   <= e_minor;
            r_left    <= {1'b0, e_major} + (CB + 1)'(1);
            r_x_dir   <= e_x_dir;
            r_y_dir   <= e_y_dir;
            r_swapped <= e_swapped;
        end else if (emit) begin
            r_cur_x <= n_x;
            r_cur_y <= n_y;
            r_err   <= n_err_wide[EW-1:0];
            r_left  <= r_left - (CB + 1)'(1);
        end
        if (emit) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_last <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_last      = r_out_last;

endmodule

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer: a start request (tuser low) loads two endpoints and
// emits nothing; each step request (tuser high) emits the next pixel of the line,
// with tlast on the final one, and a step with no line loaded emits nothing.
// Sustained rate is one request per clock while the pixel output is not stalled.
// Requests pass through a four-entry queue and then the pixel output register;
// tready drops only when that queue is full because the pixel output is stalled.
module bresenham_line_rasterizer
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  logic [in_data_w(COORD_BITS)-1:0]  i_s_axis_tdata,
    // command
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pixel_x, pixel_y
    output logic [out_data_w(COORD_BITS)-1:0] o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    localparam int CB  = COORD_BITS;
    localparam int EWD = entry_w(CB);

    logic [EWD-1:0] front_entry;
    logic [EWD-1:0] q_entry;
    logic           q_valid;
    logic           q_pop;
    logic [CB-1:0]  pixel_x;
    logic [CB-1:0]  pixel_y;

    brl_front #(
        .COORD_BITS(CB)
    ) u_front (
        .i_cmd     (i_s_axis_tuser),
        .i_x_start (i_s_axis_tdata[CB-1:0]),
        .i_y_start (i_s_axis_tdata[2*CB-1:CB]),
        .i_x_end   (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_y_end   (i_s_axis_tdata[4*CB-1:3*CB]),
        .o_entry   (front_entry)
    );

    brl_queue #(
        .WIDTH(EWD),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_data  (front_entry),
        .o_ready (o_s_axis_tready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    brl_walker #(
        .COORD_BITS(CB)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_pixel_x   (pixel_x),
        .o_pixel_y   (pixel_y),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = out_data_w(CB)'({pixel_y, pixel_x});

endmodule

// ===== hw/rtl/brl_checker.sv =====
// port-level checks for the line rasterizer, bound to the top level
module brl_checker
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [in_data_w(COORD_BITS)-1:0]  i_s_axis_tdata,
    input logic                              i_s_axis_tuser,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [out_data_w(COORD_BITS)-1:0] o_m_axis_tdata,
    input logic                              o_m_axis_tlast
);

    // stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled pixel changed");

    // reset empties queue and output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not idle after reset");

    // queue fills only through accepted requests
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("ready fell without a request");

    // pad bits above the pixel coordinates stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata >> (2 * COORD_BITS)) == '0))
        else $error("pad bits set");

    logic unused_in;
    assign unused_in = ^{i_s_axis_tdata, i_s_axis_tuser};

endmodule

bind bresenham_line_rasterizer brl_checker #(
    .COORD_BITS(COORD_BITS)
) u_brl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
